FILE: src/lh_pkg.sv
// ----------------------------------------------------------------------------
// lh_pkg: shared types, constants and helpers of the letter histogram
// Letter set, counter sizes, controller command and status bundles, and the
// byte to counter index mapping.
// ----------------------------------------------------------------------------
package lh_pkg;

    // sizes of the letter store
    localparam int NUM_LETTERS = 52;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(NUM_LETTERS);
    localparam int TOTAL_W     = 24;
    localparam int ALPHA_LEN   = 26;

    // character codes
    localparam logic [7:0] CHR_UP_A = 8'h41;
    localparam logic [7:0] CHR_UP_Z = 8'h5A;
    localparam logic [7:0] CHR_LO_A = 8'h61;
    localparam logic [7:0] CHR_LO_Z = 8'h7A;

    // result kinds
    localparam logic KIND_TOTAL  = 1'b0;
    localparam logic KIND_LETTER = 1'b1;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TOTAL_W-1:0]     t_total;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPD    = 5'b00010,
        ST_TOTAL  = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_LETTER = 5'b10000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_letter;  // capture index of the incoming byte, read its counter
        logic upd;          // write back the incremented counter
        logic sel_scan;     // counter store read address from the scan index
        logic scan_step;    // move scan index on by one
        logic emit_total;   // load total beat, start the scan
        logic emit_letter;  // load letter beat, move scan on
        logic clear_all;    // report done, empty the histogram
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_letter;    // incoming byte is a counted letter
        logic in_finish;    // incoming beat ends the text
        logic none_set;     // no letter counted
        logic pend_bit;     // counter at scan index still to report
        logic last_hit;     // counter at scan index is the last to report
        logic out_free;     // output register can take a beat
    } t_sts;

    typedef struct packed {
        logic hit;
        t_idx idx;
    } t_lookup;

    // byte to counter index, letters beyond the store are not hits
    function automatic t_lookup letter_lookup(input logic [7:0] b);
        t_lookup    r;
        logic [7:0] pos;
        r   = '0;
        pos = 8'(b - CHR_LO_A) + 8'(ALPHA_LEN);
        if (b >= CHR_UP_A && b <= CHR_UP_Z) begin
            r.hit = 1'b1;
            r.idx = IDX_W'(b - CHR_UP_A);
        end else if (b >= CHR_LO_A && b <= CHR_LO_Z) begin
            r.hit = (pos < 8'(NUM_LETTERS));
            r.idx = IDX_W'(pos);
        end
        return r;
    endfunction

    // counter index to character code
    function automatic logic [7:0] letter_code(input t_idx idx);
        logic [7:0] w;
        w = 8'(idx);
        if (w < 8'(ALPHA_LEN)) begin
            return CHR_UP_A + w;
        end
        return CHR_LO_A + (w - 8'(ALPHA_LEN));
    endfunction

    // counter value as reported, clipped to the result field
    function automatic t_total clip_count(input t_count c);
        logic [32:0] w;
        w = 33'(c);
        if (w > 33'((1 << TOTAL_W) - 1)) begin
            return '1;
        end
        return w[TOTAL_W-1:0];
    endfunction

endpackage

FILE: src/lh_ram.sv
// ----------------------------------------------------------------------------
// lh_ram: generic single write, single read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 52
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lh_ctrl.sv
// ----------------------------------------------------------------------------
// lh_ctrl: letter histogram controller
// Sequences counting, the total beat and the scan over the letter counters.
// ----------------------------------------------------------------------------
module lh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lh_pkg::t_sts  i_sts,
    output lh_pkg::t_cmd  o_cmd
);
    import lh_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_finish) begin
                        n_state = ST_TOTAL;
                    end else if (i_sts.in_letter) begin
                        cmd.take_letter = 1'b1;
                        n_state         = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                cmd.upd = 1'b1;
                n_state = ST_IDLE;
            end
            ST_TOTAL: begin
                if (i_sts.out_free) begin
                    cmd.emit_total = 1'b1;
                    if (i_sts.none_set) begin
                        cmd.clear_all = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.sel_scan = 1'b1;
                if (i_sts.pend_bit) begin
                    n_state = ST_LETTER;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_LETTER: begin
                cmd.sel_scan = 1'b1;
                if (i_sts.out_free) begin
                    cmd.emit_letter = 1'b1;
                    if (i_sts.last_hit) begin
                        cmd.clear_all = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == ST_IDLE);

endmodule

FILE: src/lh_dpath.sv
// ----------------------------------------------------------------------------
// lh_dpath: letter histogram datapath
// Counter store, nonzero flags, running total, scan index and output register.
// ----------------------------------------------------------------------------
module lh_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_text_byte,
    input  logic                    i_finish,
    input  lh_pkg::t_cmd            i_cmd,
    output lh_pkg::t_sts            o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_entry_kind,
    output logic [7:0]              o_letter_code,
    output logic [lh_pkg::TOTAL_W-1:0] o_letter_count,
    output logic                    o_last_entry
);
    import lh_pkg::*;

    t_lookup                lk;
    t_idx                   r_idx;
    t_idx                   r_scan;
    t_idx                   rd_addr;
    t_count                 q;
    t_count                 old_count;
    logic                   cnt_sat;
    logic [NUM_LETTERS-1:0] r_nz;
    logic [NUM_LETTERS-1:0] r_pend;
    logic [NUM_LETTERS-1:0] pend_left;
    t_total                 r_total;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [7:0]             r_out_code;
    t_total                 r_out_count;
    logic                   r_out_last;
    logic                   out_free;

    assign lk = letter_lookup(i_text_byte);

    // counter store
    assign rd_addr = i_cmd.sel_scan ? r_scan : lk.idx;

    lh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_LETTERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd && !cnt_sat),
        .i_waddr (r_idx),
        .i_wdata (old_count + COUNT_WIDTH'(1)),
        .i_raddr (rd_addr),
        .o_rdata (q)
    );

    // a counter never written since the last report reads as zero
    assign old_count = r_nz[r_idx] ? q : '0;
    assign cnt_sat   = &old_count;

    // byte index capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_letter) begin
            r_idx <= lk.idx;
        end
    end

    // nonzero flags and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_nz    <= '0;
            r_total <= '0;
        end else if (i_cmd.upd && !cnt_sat) begin
            r_nz[r_idx] <= 1'b1;
            if (r_total != '1) begin
                r_total <= r_total + TOTAL_W'(1);
            end
        end
    end

    // scan over counters still to report
    assign pend_left = r_pend & ~(NUM_LETTERS'(1) << r_scan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_scan <= '0;
        end else if (i_cmd.emit_total) begin
            r_pend <= r_nz;
            r_scan <= '0;
        end else if (i_cmd.emit_letter) begin
            r_pend <= pend_left;
            r_scan <= r_scan + IDX_W'(1);
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + IDX_W'(1);
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_total || i_cmd.emit_letter) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_total) begin
            r_out_kind  <= KIND_TOTAL;
            r_out_code  <= '0;
            r_out_count <= r_total;
            r_out_last  <= ~|r_nz;
        end else if (i_cmd.emit_letter) begin
            r_out_kind  <= KIND_LETTER;
            r_out_code  <= letter_code(r_scan);
            r_out_count <= clip_count(q);
            r_out_last  <= ~|pend_left;
        end
    end

    // status to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.in_letter = lk.hit;
        o_sts.in_finish = i_finish;
        o_sts.none_set  = ~|r_nz;
        o_sts.pend_bit  = r_pend[r_scan];
        o_sts.last_hit  = ~|pend_left;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_kind   = r_out_kind;
    assign o_letter_code  = r_out_code;
    assign o_letter_count = r_out_count;
    assign o_last_entry   = r_out_last;

endmodule

FILE: src/letter_histogram.sv
// ----------------------------------------------------------------------------
// letter_histogram: ASCII letter counter with histogram report
// Counts letters of a byte stream and reports the totals on a finish beat.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one text byte, s_axis_tlast marks the
// finish beat, whose byte is ignored. Letters A..Z and a..z each bump their
// own saturating counter and a 24-bit running total; other bytes are dropped.
// Output stream: after a finish beat the block sends the total (tuser 0,
// letter code 0), then one beat per letter with a nonzero count in the order
// A..Z then a..z (tuser 1), with tlast on the final beat of the report.
// Input: a non-letter beat leaves s_axis_tready high; after a letter beat
// it drops while the count is written back, as each count is a read then
// a write of the counter memory. A report holds s_axis_tready low while the
// total beat is loaded, each counter index up to the last nonzero one is
// scanned and each letter beat is loaded; the total beat goes first.
// A stalled receiver holds the report in the output register; the scan
// waits and nothing is lost. The block takes the next text byte while the
// final report beat still waits to be taken.
// Reset (synchronous, active low) empties the histogram at once through
// per-counter flags; the counters are cleared the same way after each report.
// ----------------------------------------------------------------------------
module letter_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // finish
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] letter_code, [31:8] letter_count
    output logic        m_axis_tuser,   // entry_kind
    output logic        m_axis_tlast    // last_entry
);
    import lh_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] letter_code_w;
    t_total     letter_count_w;

    // controller
    lh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    lh_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_byte    (s_axis_tdata),
        .i_finish       (s_axis_tlast),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_entry_kind   (m_axis_tuser),
        .o_letter_code  (letter_code_w),
        .o_letter_count (letter_count_w),
        .o_last_entry   (m_axis_tlast)
    );

    assign m_axis_tdata = {letter_count_w, letter_code_w};

endmodule

FILE: src/lh_checker.sv
// ----------------------------------------------------------------------------
// lh_checker: port level checks of the letter histogram
// Watches the stream ports and flags report beats that cannot be right.
// ----------------------------------------------------------------------------
module lh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // total beat carries no letter code
    a_total_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
        else $error("total beat with a letter code");

    // letter beat names a letter
    a_letter_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[7:0] >= 8'h41 && m_axis_tdata[7:0] <= 8'h5A) ||
            (m_axis_tdata[7:0] >= 8'h61 && m_axis_tdata[7:0] <= 8'h7A))
        else $error("letter beat with a non-letter code");

    // only nonzero letters are reported
    a_letter_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:8] != 24'h0)
        else $error("letter beat with a zero count");

    // input closes while a report starts
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open right after a finish beat");

endmodule

bind letter_histogram lh_checker u_lh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the letter histogram
// Streams text beats into the block and keeps a shadow histogram that
// predicts every report beat. The input side and the output side both stall
// at random, with calm stretches. A directed opening covers letter
// boundaries and empty reports, then every letter once for the longest
// report. Random sentences follow.
// ----------------------------------------------------------------------------
module tb;
    import lh_pkg::*;

    localparam int           IDLE_PCT = 11;
    localparam int           MAX_SHOWN = 10;
    localparam int           SETTLE_CYC = 200;
    localparam int           RUN_ITEMS = 295;
    localparam longint       CNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
    localparam longint       TOT_MAX = (64'd1 << TOTAL_W) - 1;

    // one text beat waiting to be sent
    typedef struct {
        logic [7:0] text_byte;
        logic       finish;
        logic       drain;      // hold this beat until every report beat has come
    } t_text_beat;

    // one report beat as the block should send it
    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        t_total     count;
        logic       last;
    } t_hist_beat;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;      // finish
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // [7:0] letter_code, [31:8] letter_count
    logic        m_axis_tuser;             // entry_kind
    logic        m_axis_tlast;             // last_entry

    t_text_beat  text_q[$];
    t_hist_beat  report_q[$];
    longint      hist_cnt[NUM_LETTERS];
    longint      hist_total;
    int unsigned cyc_cnt = 0;
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          reports = 0;
    int          pauses = 0;
    logic        quiet;

    letter_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // calm stretches with no stalls on either side
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
    end
    assign quiet = (cyc_cnt % 4096) < 700;

    // counter slot of a byte, -1 when the byte is not counted
    function automatic int slot_of(input logic [7:0] b);
        int idx;
        idx = -1;
        if (b >= CHR_UP_A && b <= CHR_UP_Z) begin
            idx = int'(b) - int'(CHR_UP_A);
        end else if (b >= CHR_LO_A && b <= CHR_LO_Z) begin
            idx = int'(b) - int'(CHR_LO_A) + ALPHA_LEN;
        end
        if (idx >= NUM_LETTERS) begin
            idx = -1;
        end
        return idx;
    endfunction

    // character of a counter slot
    function automatic logic [7:0] char_of(input int idx);
        if (idx < ALPHA_LEN) begin
            return CHR_UP_A + 8'(idx);
        end
        return CHR_LO_A + 8'(idx - ALPHA_LEN);
    endfunction

    function automatic t_total clip24(input longint v);
        return (v > TOT_MAX) ? t_total'(TOT_MAX) : t_total'(v);
    endfunction

    // shadow histogram: count a letter, or queue the report on a finish beat
    task automatic book_text_beat(input logic [7:0] b, input logic fin);
        int         idx;
        int         last_idx;
        t_hist_beat hb;
        if (!fin) begin
            idx = slot_of(b);
            if (idx >= 0 && hist_cnt[idx] < CNT_MAX) begin
                hist_cnt[idx]++;
                if (hist_total < TOT_MAX) begin
                    hist_total++;
                end
            end
        end else begin
            last_idx = -1;
            for (int i = 0; i < NUM_LETTERS; i++) begin
                if (hist_cnt[i] != 0) begin
                    last_idx = i;
                end
            end
            hb.kind  = KIND_TOTAL;
            hb.code  = 8'h00;
            hb.count = clip24(hist_total);
            hb.last  = (last_idx < 0);
            report_q.push_back(hb);
            for (int i = 0; i < NUM_LETTERS; i++) begin
                if (hist_cnt[i] != 0) begin
                    hb.kind  = KIND_LETTER;
                    hb.code  = char_of(i);
                    hb.count = clip24(hist_cnt[i]);
                    hb.last  = (i == last_idx);
                    report_q.push_back(hb);
                end
                hist_cnt[i] = 0;
            end
            hist_total = 0;
            reports++;
        end
    endtask

    task automatic add_beat(input logic [7:0] b, input logic fin, input logic drain);
        t_text_beat tb_item;
        tb_item.text_byte = b;
        tb_item.finish    = fin;
        tb_item.drain     = drain;
        text_q.push_back(tb_item);
    endtask

    // input side: present queued beats, idle at random
    always @(posedge i_clk) begin : drive_text
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        t_text_beat it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nv = s_axis_tvalid;
            nd = s_axis_tdata;
            nl = s_axis_tlast;
            if (s_axis_tvalid && s_axis_tready) begin
                book_text_beat(s_axis_tdata, s_axis_tlast);
                beats_in++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (text_q.size() > 0 && !(text_q[0].drain && report_q.size() != 0)
                        && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    it = text_q.pop_front();
                    if (it.drain) begin
                        pauses++;
                    end
                    nv = 1'b1;
                    nd = it.text_byte;
                    nl = it.finish;
                end else begin
                    nd = 8'($urandom);
                    nl = 1'($urandom);
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            s_axis_tlast  <= nl;
        end
    end

    // output side: check each report beat against the oldest prediction
    always @(posedge i_clk) begin : watch_report
        t_hist_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out++;
                if (report_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("unexpected report beat: kind %0d code %02h count %0d last %0d",
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[31:8],
                                 m_axis_tlast);
                    end
                end else begin
                    want = report_q.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.code
                            || m_axis_tdata[31:8] !== want.count
                            || m_axis_tlast !== want.last) begin
                        errors++;
                        if (errors <= MAX_SHOWN) begin
                            $display({"report beat %0d mismatch: exp kind %0d code %02h ",
                                      "count %0d last %0d, got kind %0d code %02h ",
                                      "count %0d last %0d"},
                                     beats_out, want.kind, want.code, want.count, want.last,
                                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[31:8],
                                     m_axis_tlast);
                        end
                    end
                end
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        int         len;
        int         idx;
        int         tmp;
        int         perm[NUM_LETTERS];
        logic [7:0] b;
        logic       drain;

        for (int i = 0; i < NUM_LETTERS; i++) begin
            hist_cnt[i] = 0;
        end
        hist_total = 0;

        // directed: empty report, letter boundaries, non-letters
        add_beat(CHR_UP_A, 1'b1, 1'b0);
        add_beat(CHR_UP_A, 1'b0, 1'b0);
        add_beat(CHR_UP_Z, 1'b0, 1'b0);
        add_beat(CHR_LO_A, 1'b0, 1'b0);
        add_beat(CHR_LO_Z, 1'b0, 1'b0);
        add_beat(CHR_UP_A - 8'd1, 1'b0, 1'b0);
        add_beat(CHR_UP_Z + 8'd1, 1'b0, 1'b0);
        add_beat(CHR_LO_A - 8'd1, 1'b0, 1'b0);
        add_beat(CHR_LO_Z + 8'd1, 1'b0, 1'b0);
        add_beat(8'h20, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b0);
        add_beat(8'hFF, 1'b0, 1'b0);
        add_beat(8'h80 | CHR_UP_A, 1'b0, 1'b0);
        add_beat(CHR_UP_A, 1'b0, 1'b0);
        add_beat(CHR_LO_A + 8'd12, 1'b0, 1'b0);
        add_beat(CHR_LO_Z, 1'b1, 1'b0);
        add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'hFF, 1'b1, 1'b1);

        // every letter once in shuffled order: the longest report
        for (int i = 0; i < NUM_LETTERS; i++) begin
            perm[i] = i;
        end
        for (int i = NUM_LETTERS - 1; i > 0; i--) begin
            idx       = $urandom_range(0, i);
            tmp       = perm[i];
            perm[i]   = perm[idx];
            perm[idx] = tmp;
        end
        for (int i = 0; i < NUM_LETTERS; i++) begin
            add_beat(char_of(perm[i]), 1'b0, 1'b0);
        end
        add_beat(8'($urandom), 1'b1, 1'b0);

        // random sentences, some running into the next without a finish
        while (text_q.size() < RUN_ITEMS) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 30);
            if (len > RUN_ITEMS - text_q.size()) begin
                len = RUN_ITEMS - text_q.size();
            end
            drain = ($urandom_range(0, 9) == 0);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) < 7) begin
                    b = char_of($urandom_range(0, NUM_LETTERS - 1));
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                add_beat(b, 1'b0, drain);
                drain = 1'b0;
            end
            if ($urandom_range(0, 7) != 0) begin
                add_beat(8'($urandom), 1'b1, drain);
            end
        end
        add_beat(8'($urandom), 1'b1, 1'b0);

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the input queue and the expected beats to run dry
        while (text_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("text beats sent %0d, reports %0d, report beats checked %0d",
                 beats_in, reports, beats_out);
        $display("drain pauses %0d, failures %0d", pauses, errors);
        if (errors == 0 && report_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
